// ===== src/assert_macros.svh =====
// Assertion macros shared by the RTL of the scalar Kalman filter.
// No dependencies; define ASSERT_OFF to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, disabled while reset is low
`define SKF_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is low
`define SKF_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`else

`define SKF_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define SKF_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

// ===== src/skf_pkg.sv =====
// Shared types, constants and the microcode ROM of the scalar Kalman filter.
// No dependencies.
package skf_pkg;

  // configuration port
  localparam int CFG_AW = 4;
  localparam int CFG_DW = 32;

  // fixed-point widths
  localparam int COV_W  = 32;   // Q8.24 covariance and noise terms
  localparam int FRAC_W = 24;   // fraction bits of gain and covariance
  localparam int GAIN_W = 25;   // Q1.24 gain, up to exactly 1.0
  localparam int DEN_W  = COV_W + 1;
  localparam int REM_W  = COV_W + 2;

  localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(1) << FRAC_W;

  // sequencer
  localparam int STEP_W = 4;
  localparam int CNT_W  = 5;
  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(GAIN_W - 1);

  typedef logic [STEP_W-1:0] skf_step_t;

  // register map, index = paddr / 4
  typedef enum logic [1:0] {
    REG_PNOISE,
    REG_MNOISE,
    REG_INIT_EST,
    REG_INIT_COV
  } skf_reg_t;

  // datapath operations
  typedef enum logic [3:0] {
    OP_NOP,
    OP_ACCEPT,
    OP_PRED,
    OP_DENOM,
    OP_DIV,
    OP_GAIN,
    OP_MUL_EST,
    OP_EST_COV,
    OP_FINISH
  } skf_op_t;

  // jump conditions
  typedef enum logic [2:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_NO_INPUT,
    COND_LOOP,
    COND_OUT_BUSY
  } skf_cond_t;

  // one microcode word
  typedef struct packed {
    logic      in_rdy;
    logic      cnt_load;
    skf_cond_t cond;
    skf_step_t target;
    skf_op_t   op;
  } skf_uop_t;

  // status fed back to the sequencer
  typedef struct packed {
    logic in_valid;
    logic out_busy;
  } skf_stat_t;

  // program addresses
  localparam skf_step_t ST_ACCEPT   = 4'd0;
  localparam skf_step_t ST_PRED     = 4'd1;
  localparam skf_step_t ST_DENOM    = 4'd2;
  localparam skf_step_t ST_DIV      = 4'd3;
  localparam skf_step_t ST_GAIN     = 4'd4;
  localparam skf_step_t ST_MUL_EST  = 4'd5;
  localparam skf_step_t ST_EST_COV  = 4'd6;
  localparam skf_step_t ST_WAIT_OUT = 4'd7;
  localparam skf_step_t ST_FINISH   = 4'd8;

  // Microcode ROM: jump to target when cond holds, else fall through
  function automatic skf_uop_t ucode(input skf_step_t step);
    skf_uop_t u;
    u = '{in_rdy: 1'b0, cnt_load: 1'b0, cond: COND_NEVER,
          target: ST_ACCEPT, op: OP_NOP};
    unique case (step)
      ST_ACCEPT: begin
        u.in_rdy = 1'b1;
        u.op     = OP_ACCEPT;
        u.cond   = COND_NO_INPUT;
        u.target = ST_ACCEPT;
      end
      ST_PRED:  u.op = OP_PRED;
      ST_DENOM: begin
        u.op       = OP_DENOM;
        u.cnt_load = 1'b1;
      end
      ST_DIV: begin
        u.op     = OP_DIV;
        u.cond   = COND_LOOP;
        u.target = ST_DIV;
      end
      ST_GAIN:    u.op = OP_GAIN;
      ST_MUL_EST: u.op = OP_MUL_EST;
      ST_EST_COV: u.op = OP_EST_COV;
      ST_WAIT_OUT: begin
        u.cond   = COND_OUT_BUSY;
        u.target = ST_WAIT_OUT;
      end
      ST_FINISH: begin
        u.op     = OP_FINISH;
        u.cond   = COND_ALWAYS;
        u.target = ST_ACCEPT;
      end
      default: begin
        u.cond   = COND_ALWAYS;
        u.target = ST_ACCEPT;
      end
    endcase
    return u;
  endfunction

endpackage

// ===== src/skf_in_if.sv =====
// Measurement channel: valid/ready handshake with one signed sample.
// No dependencies.
interface skf_in_if #(
  parameter int SAMPLE_WIDTH = 16
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] measurement;

  modport source (output valid, output measurement, input ready);
  modport sink   (input valid, input measurement, output ready);
endinterface

// ===== src/skf_out_if.sv =====
// Result channel: valid/ready handshake with estimate, gain and variance.
// Depends on skf_pkg for the fixed widths.
interface skf_out_if #(
  parameter int SAMPLE_WIDTH = 16
);
  logic                               valid;
  logic                               ready;
  logic signed [SAMPLE_WIDTH-1:0]     estimate;
  logic [skf_pkg::GAIN_W-1:0]         gain;
  logic [skf_pkg::COV_W-1:0]          variance;

  modport source (output valid, output estimate, output gain, output variance,
                  input ready);
  modport sink   (input valid, input estimate, input gain, input variance,
                  output ready);
endinterface

// ===== src/skf_regs.sv =====
// APB-style configuration registers of the Kalman filter, with reload strobe.
// Depends on skf_pkg.
module skf_regs #(
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [skf_pkg::CFG_AW-1:0]    paddr,
  input  logic [skf_pkg::CFG_DW-1:0]    pwdata,
  output logic [skf_pkg::CFG_DW-1:0]    prdata,
  output logic [skf_pkg::COV_W-1:0]     pnoise,
  output logic [skf_pkg::COV_W-1:0]     mnoise,
  output logic [SAMPLE_WIDTH-1:0]       init_est,
  output logic [skf_pkg::COV_W-1:0]     init_cov,
  output logic                          reload
);

  logic [skf_pkg::COV_W-1:0] pnoise_r;
  logic [skf_pkg::COV_W-1:0] mnoise_r;
  logic [SAMPLE_WIDTH-1:0]   init_est_r;
  logic [skf_pkg::COV_W-1:0] init_cov_r;
  logic                      reload_r;
  logic                      wr;
  skf_pkg::skf_reg_t         idx;

  assign wr  = psel & penable & pwrite;
  assign idx = skf_pkg::skf_reg_t'(paddr[skf_pkg::CFG_AW-1:2]);

  // register file; reload strobe follows every write and reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pnoise_r   <= 32'd17;
      mnoise_r   <= 32'd1677722;
      init_est_r <= SAMPLE_WIDTH'(32'd6400);
      init_cov_r <= 32'd83886080;
      reload_r   <= 1'b1;
    end else begin
      reload_r <= wr;
      if (wr) begin
        unique case (idx)
          skf_pkg::REG_PNOISE:   pnoise_r   <= pwdata;
          skf_pkg::REG_MNOISE:   mnoise_r   <= pwdata;
          skf_pkg::REG_INIT_EST: init_est_r <= pwdata[SAMPLE_WIDTH-1:0];
          skf_pkg::REG_INIT_COV: init_cov_r <= pwdata;
          default: ;
        endcase
      end
    end
  end

  // read mux
  always_comb begin
    unique case (idx)
      skf_pkg::REG_PNOISE:   prdata = pnoise_r;
      skf_pkg::REG_MNOISE:   prdata = mnoise_r;
      skf_pkg::REG_INIT_EST: prdata = skf_pkg::CFG_DW'(init_est_r);
      skf_pkg::REG_INIT_COV: prdata = init_cov_r;
      default:               prdata = '0;
    endcase
  end

  assign pnoise   = pnoise_r;
  assign mnoise   = mnoise_r;
  assign init_est = init_est_r;
  assign init_cov = init_cov_r;
  assign reload   = reload_r;

endmodule

// ===== src/skf_seq.sv =====
// Microcode sequencer: step counter, loop counter and conditional jumps.
// Depends on skf_pkg (ROM contents and control word types).
module skf_seq (
  input  logic                clk,
  input  logic                rst_n,
  input  skf_pkg::skf_stat_t  stat,
  output skf_pkg::skf_uop_t   uop,
  output skf_pkg::skf_step_t  step
);

  skf_pkg::skf_step_t        step_r;
  skf_pkg::skf_step_t        step_nxt;
  logic [skf_pkg::CNT_W-1:0] cnt_r;
  logic [skf_pkg::CNT_W-1:0] cnt_nxt;
  logic                      take;

  // ROM fetch, jump decision and loop count
  always_comb begin
    uop = skf_pkg::ucode(step_r);
    unique case (uop.cond)
      skf_pkg::COND_NEVER:    take = 1'b0;
      skf_pkg::COND_ALWAYS:   take = 1'b1;
      skf_pkg::COND_NO_INPUT: take = !stat.in_valid;
      skf_pkg::COND_LOOP:     take = (cnt_r != '0);
      skf_pkg::COND_OUT_BUSY: take = stat.out_busy;
      default:                take = 1'b0;
    endcase
    step_nxt = take ? uop.target : step_r + 1'b1;

    cnt_nxt = cnt_r;
    if (uop.cnt_load) begin
      cnt_nxt = skf_pkg::DIV_LAST;
    end else if (uop.op == skf_pkg::OP_DIV && cnt_r != '0) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= skf_pkg::ST_ACCEPT;
      cnt_r  <= '0;
    end else begin
      step_r <= step_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  assign step = step_r;

endmodule

// ===== src/skf_dp.sv =====
// Kalman filter datapath: state, restoring divider, shared multiplier,
// rounding/saturation and the result register. Depends on skf_pkg.
module skf_dp #(
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  skf_pkg::skf_uop_t                 uop,
  input  logic [skf_pkg::COV_W-1:0]         pnoise,
  input  logic [skf_pkg::COV_W-1:0]         mnoise,
  input  logic [SAMPLE_WIDTH-1:0]           init_est,
  input  logic [skf_pkg::COV_W-1:0]         init_cov,
  input  logic                              reload,
  input  logic signed [SAMPLE_WIDTH-1:0]    in_measurement,
  input  logic                              out_ready,
  output logic                              out_valid,
  output logic signed [SAMPLE_WIDTH-1:0]    out_estimate,
  output logic [skf_pkg::GAIN_W-1:0]        out_gain,
  output logic [skf_pkg::COV_W-1:0]         out_variance,
  output logic                              out_busy
);

  localparam int SW   = SAMPLE_WIDTH;
  localparam int MB_W = (SW + 1 > skf_pkg::COV_W + 1) ? SW + 1 : skf_pkg::COV_W + 1;
  localparam int PW   = skf_pkg::GAIN_W + 1 + MB_W;
  localparam logic signed [PW-1:0]   RND_HALF = PW'(64'd1 << (skf_pkg::FRAC_W - 1));
  localparam logic signed [SW+1:0]   EST_MAX  = (SW + 2)'({1'b0, {(SW - 1){1'b1}}});
  localparam logic signed [SW+1:0]   EST_MIN  = ~EST_MAX;

  // state and work registers
  logic signed [SW-1:0]          meas_r;
  logic signed [SW-1:0]          est_r;
  logic [skf_pkg::COV_W-1:0]     cov_r;
  logic [skf_pkg::COV_W-1:0]     pred_r;
  logic signed [SW:0]            diff_r;
  logic [skf_pkg::DEN_W-1:0]     den_r;
  logic [skf_pkg::REM_W-1:0]     rem_r;
  logic [skf_pkg::GAIN_W-1:0]    quo_r;
  logic [skf_pkg::GAIN_W-1:0]    gain_r;
  logic signed [PW-1:0]          prod_r;
  logic                          out_valid_r;
  logic signed [SW-1:0]          out_est_r;
  logic [skf_pkg::GAIN_W-1:0]    out_gain_r;
  logic [skf_pkg::COV_W-1:0]     out_var_r;

  // combinational terms
  logic [skf_pkg::COV_W:0]       cov_sum;
  logic [skf_pkg::COV_W-1:0]     pred_sat;
  logic [skf_pkg::DEN_W-1:0]     den_sum;
  logic                          rem_ge;
  logic [skf_pkg::REM_W-1:0]     rem_sub;
  logic signed [skf_pkg::GAIN_W:0] mul_a;
  logic signed [MB_W-1:0]        mul_b;
  logic signed [PW-1:0]          mul_p;
  logic signed [PW-1:0]          prod_rnd;
  logic signed [PW-1:0]          delta_full;
  logic signed [SW+1:0]          est_sum;
  logic signed [SW-1:0]          est_new;
  logic [skf_pkg::COV_W:0]       cov_full;
  logic [skf_pkg::COV_W-1:0]     cov_new;

  // predicted covariance, saturating, and gain denominator
  assign cov_sum  = {1'b0, cov_r} + {1'b0, pnoise};
  assign pred_sat = cov_sum[skf_pkg::COV_W] ? '1 : cov_sum[skf_pkg::COV_W-1:0];
  assign den_sum  = {1'b0, pred_r} + {1'b0, mnoise};

  // one restoring-division step: compare, subtract, shift
  assign rem_ge  = (rem_r >= {1'b0, den_r});
  assign rem_sub = rem_ge ? rem_r - {1'b0, den_r} : rem_r;

  // shared multiplier: gain * diff, then (1 - gain) * pred
  always_comb begin
    if (uop.op == skf_pkg::OP_EST_COV) begin
      mul_a = $signed({1'b0, skf_pkg::GAIN_ONE - gain_r});
      mul_b = MB_W'($signed({1'b0, pred_r}));
    end else begin
      mul_a = $signed({1'b0, gain_r});
      mul_b = MB_W'(diff_r);
    end
  end
  assign mul_p = mul_a * mul_b;

  // estimate: round half up to Q8.8, add, saturate
  assign prod_rnd   = prod_r + RND_HALF;
  assign delta_full = prod_rnd >>> skf_pkg::FRAC_W;
  assign est_sum    = (SW + 2)'(est_r) + $signed(delta_full[SW+1:0]);
  always_comb begin
    if (est_sum > EST_MAX) begin
      est_new = EST_MAX[SW-1:0];
    end else if (est_sum < EST_MIN) begin
      est_new = EST_MIN[SW-1:0];
    end else begin
      est_new = est_sum[SW-1:0];
    end
  end

  // covariance: round to nearest, clamp to 32 bits
  assign cov_full = prod_rnd[skf_pkg::FRAC_W + skf_pkg::COV_W : skf_pkg::FRAC_W];
  assign cov_new  = cov_full[skf_pkg::COV_W] ? '1 : cov_full[skf_pkg::COV_W-1:0];

  // filter state, reloaded after reset and after every register write
  always_ff @(posedge clk) begin
    if (reload) begin
      est_r <= $signed(init_est);
      cov_r <= init_cov;
    end else begin
      if (uop.op == skf_pkg::OP_EST_COV) begin
        est_r <= est_new;
      end
      if (uop.op == skf_pkg::OP_FINISH) begin
        cov_r <= cov_new;
      end
    end
  end

  // work registers
  always_ff @(posedge clk) begin
    unique case (uop.op)
      skf_pkg::OP_ACCEPT: meas_r <= in_measurement;
      skf_pkg::OP_PRED: begin
        pred_r <= pred_sat;
        diff_r <= (SW + 1)'(meas_r) - (SW + 1)'(est_r);
      end
      skf_pkg::OP_DENOM: begin
        den_r <= den_sum;
        rem_r <= {2'b00, pred_r};
        quo_r <= '0;
      end
      skf_pkg::OP_DIV: begin
        quo_r <= {quo_r[skf_pkg::GAIN_W-2:0], rem_ge};
        rem_r <= {rem_sub[skf_pkg::REM_W-2:0], 1'b0};
      end
      skf_pkg::OP_GAIN:    gain_r <= (den_r == '0) ? '0 : quo_r;
      skf_pkg::OP_MUL_EST: prod_r <= mul_p;
      skf_pkg::OP_EST_COV: prod_r <= mul_p;
      skf_pkg::OP_FINISH: begin
        out_est_r  <= est_r;
        out_gain_r <= gain_r;
        out_var_r  <= cov_new;
      end
      default: ;
    endcase
  end

  // result register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (uop.op == skf_pkg::OP_FINISH) begin
        out_valid_r <= 1'b1;
      end
    end
  end

  assign out_valid    = out_valid_r;
  assign out_estimate = out_est_r;
  assign out_gain     = out_gain_r;
  assign out_variance = out_var_r;
  assign out_busy     = out_valid_r & ~out_ready;

endmodule

// ===== src/scalar_kalman_filter.sv =====
// Scalar Kalman filter (constant-state model), top level.
// Depends on skf_pkg, skf_in_if, skf_out_if, skf_regs, skf_seq, skf_dp and
// assert_macros.svh.
//
//   channel   direction  handshake             payload
//   in_ch     sink       valid/ready           measurement (signed Q8.8)
//   out_ch    source     valid/ready           estimate, gain (Q1.24), variance
//   apb       slave      psel/penable/pready   paddr, pwdata, prdata
//
// An item runs accept, predict, denominator, divide, gain, multiply, update,
// wait and finish before the next is accepted; the gain's restoring divider
// gives one quotient bit per cycle. Reset is synchronous, active low; the
// filter state loads from the initial registers in the cycle after reset and
// after each register write. A result waiting on out_ch does not block the
// next measurement; the sequencer only holds before writing a new result.
`include "assert_macros.svh"

module scalar_kalman_filter #(
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  skf_in_if.sink                        in_ch,
  skf_out_if.source                     out_ch,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [skf_pkg::CFG_AW-1:0]    paddr,
  input  logic [skf_pkg::CFG_DW-1:0]    pwdata,
  output logic [skf_pkg::CFG_DW-1:0]    prdata,
  output logic                          pready
);

  logic [skf_pkg::COV_W-1:0] pnoise;
  logic [skf_pkg::COV_W-1:0] mnoise;
  logic [SAMPLE_WIDTH-1:0]   init_est;
  logic [skf_pkg::COV_W-1:0] init_cov;
  logic                      reload;
  logic                      out_busy;
  skf_pkg::skf_uop_t         uop;
  skf_pkg::skf_step_t        step;
  skf_pkg::skf_stat_t        stat;

  assign pready = 1'b1;

  // configuration registers
  skf_regs #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_regs (
    .clk      (clk),
    .rst_n    (rst_n),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pnoise   (pnoise),
    .mnoise   (mnoise),
    .init_est (init_est),
    .init_cov (init_cov),
    .reload   (reload)
  );

  // microcode sequencer
  assign stat.in_valid = in_ch.valid;
  assign stat.out_busy = out_busy;

  skf_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .uop   (uop),
    .step  (step)
  );

  assign in_ch.ready = uop.in_rdy;

  // datapath
  skf_dp #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .uop            (uop),
    .pnoise         (pnoise),
    .mnoise         (mnoise),
    .init_est       (init_est),
    .init_cov       (init_cov),
    .reload         (reload),
    .in_measurement (in_ch.measurement),
    .out_ready      (out_ch.ready),
    .out_valid      (out_ch.valid),
    .out_estimate   (out_ch.estimate),
    .out_gain       (out_ch.gain),
    .out_variance   (out_ch.variance),
    .out_busy       (out_busy)
  );

  // checks
  `SKF_ASSERT_IMP(a_accept_at_head, clk, rst_n, in_ch.valid && in_ch.ready, step == skf_pkg::ST_ACCEPT, "measurement taken away from the program head")
  `SKF_ASSERT_NXT(a_accept_starts, clk, rst_n, in_ch.valid && in_ch.ready, step == skf_pkg::ST_PRED, "accepted transfer did not start the program")
  `SKF_ASSERT_IMP(a_result_from_finish, clk, rst_n, $rose(out_ch.valid), $past(step) == skf_pkg::ST_FINISH, "result raised outside the finish step")
  `SKF_ASSERT_IMP(a_gain_bound, clk, rst_n, out_ch.valid, out_ch.gain <= skf_pkg::GAIN_ONE, "gain above one")

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the scalar Kalman filter: measurements in, results out.
// Depends on skf_pkg, skf_in_if, skf_out_if and scalar_kalman_filter from the RTL.
// A local fixed-point model of the filter predicts every result; APB writes change the noise setup.
`timescale 1ns / 1ps

module tb_top;

  typedef struct {
    logic signed [15:0]         estimate;
    logic [skf_pkg::GAIN_W-1:0] gain;
    logic [skf_pkg::COV_W-1:0]  variance;
  } filt_result_t;

  localparam longint unsigned Q24_ONE  = 64'd16777216;
  localparam longint unsigned Q24_HALF = 64'd8388608;
  localparam longint unsigned COV_MAX  = 64'hFFFF_FFFF;

  logic clk;
  logic rst_n;
  logic psel;
  logic penable;
  logic pwrite;
  logic [skf_pkg::CFG_AW-1:0] paddr;
  logic [skf_pkg::CFG_DW-1:0] pwdata;
  logic [skf_pkg::CFG_DW-1:0] prdata;
  logic pready;

  skf_in_if  #(.SAMPLE_WIDTH(16)) in_if ();
  skf_out_if #(.SAMPLE_WIDTH(16)) out_if ();

  scalar_kalman_filter #(.SAMPLE_WIDTH(16)) u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_if),
    .out_ch  (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // filter model: configuration and state
  logic [31:0]        pnoise_q;
  logic [31:0]        mnoise_q;
  logic signed [15:0] init_est_q;
  logic [31:0]        init_cov_q;
  logic signed [15:0] est_q;
  logic [31:0]        cov_q;

  logic signed [15:0] sample_q[$];
  filt_result_t       expected_q[$];
  filt_result_t       head_exp;

  int   err_count;
  int   in_gap;
  int   out_stall;
  int   out_draw;
  bit   no_idle;
  logic in_acc;
  logic out_acc;

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // watchdog
  initial begin
    #6_000_000;
    $display("== FAIL ==");
    $finish;
  end

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    $display("MISMATCH %s: got %0h expected %0h", what, got, want);
    err_count++;
  endtask

  function automatic int draw_gap();
    return no_idle ? 0 : $urandom_range(0, 13);
  endfunction

  // one filter step: predict, gain, update estimate and covariance
  function automatic filt_result_t kalman_update(input logic signed [15:0] meas);
    longint unsigned pred, denom, gain_u, cov_u;
    longint          diff, prod, delta, est_l;
    filt_result_t    r;
    pred = 64'(cov_q) + 64'(pnoise_q);
    if (pred > COV_MAX) pred = COV_MAX;
    denom  = pred + 64'(mnoise_q);
    gain_u = (denom == 0) ? 64'd0 : (pred << 24) / denom;
    if (gain_u > Q24_ONE) gain_u = Q24_ONE;
    diff  = longint'(meas) - longint'(est_q);
    prod  = longint'(gain_u) * diff;
    // round half up, floor via arithmetic shift
    delta = (prod + longint'(Q24_HALF)) >>> 24;
    est_l = longint'(est_q) + delta;
    if (est_l > 32767) est_l = 32767;
    if (est_l < -32768) est_l = -32768;
    cov_u = ((Q24_ONE - gain_u) * pred + Q24_HALF) >> 24;
    if (cov_u > COV_MAX) cov_u = COV_MAX;
    est_q = 16'(est_l);
    cov_q = 32'(cov_u);
    r.estimate = est_q;
    r.gain     = skf_pkg::GAIN_W'(gain_u);
    r.variance = cov_q;
    return r;
  endfunction

  // transfer flags and result checking
  always @(posedge clk) begin
    in_acc  <= rst_n && in_if.valid && in_if.ready;
    out_acc <= rst_n && out_if.valid && out_if.ready;
    if (rst_n) begin
      if (out_if.valid && out_if.ready) begin
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected result, estimate", 64'(out_if.estimate), 0);
        end else begin
          head_exp = expected_q.pop_front();
          if (out_if.estimate !== head_exp.estimate)
            report_mismatch("estimate", 64'(out_if.estimate), 64'(head_exp.estimate));
          if (out_if.gain !== head_exp.gain)
            report_mismatch("gain", 64'(out_if.gain), 64'(head_exp.gain));
          if (out_if.variance !== head_exp.variance)
            report_mismatch("variance", 64'(out_if.variance), 64'(head_exp.variance));
        end
      end
      if (in_if.valid && in_if.ready)
        expected_q.push_back(kalman_update(in_if.measurement));
    end
  end

  // measurement driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
      in_gap      <= draw_gap();
    end else if (in_if.valid && !in_acc) begin
      // hold until the transfer
    end else if (in_gap != 0) begin
      in_if.valid <= 1'b0;
      in_gap      <= in_gap - 1;
    end else if (sample_q.size() != 0) begin
      in_if.valid       <= 1'b1;
      in_if.measurement <= sample_q.pop_front();
      in_gap            <= draw_gap();
    end else begin
      in_if.valid <= 1'b0;
    end
  end

  // result sink with random back-pressure
  always @(negedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      out_stall    <= 0;
    end else if (out_acc) begin
      out_draw      = draw_gap();
      out_if.ready <= (out_draw == 0);
      out_stall    <= out_draw;
    end else if (out_stall != 0) begin
      out_if.ready <= (out_stall == 1);
      out_stall    <= out_stall - 1;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  // APB write; any write reloads the filter state
  task automatic write_reg(input skf_pkg::skf_reg_t idx, input logic [31:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= skf_pkg::CFG_AW'({idx, 2'b00});
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      skf_pkg::REG_PNOISE:   pnoise_q   = val;
      skf_pkg::REG_MNOISE:   mnoise_q   = val;
      skf_pkg::REG_INIT_EST: init_est_q = val[15:0];
      skf_pkg::REG_INIT_COV: init_cov_q = val;
      default: ;
    endcase
    est_q = init_est_q;
    cov_q = init_cov_q;
  endtask

  task automatic set_filter(input logic [31:0] pn, input logic [31:0] mn,
                            input logic signed [15:0] ie, input logic [31:0] ic);
    write_reg(skf_pkg::REG_PNOISE, pn);
    write_reg(skf_pkg::REG_MNOISE, mn);
    write_reg(skf_pkg::REG_INIT_EST, {{16{ie[15]}}, ie});
    write_reg(skf_pkg::REG_INIT_COV, ic);
    repeat (2) @(posedge clk);
  endtask

  // drain all outstanding results, then let the sequencer settle
  task automatic wait_idle();
    int guard;
    guard = 0;
    while (!(sample_q.size() == 0 && !in_if.valid && expected_q.size() == 0)
           && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    if (guard >= 20000)
      report_mismatch("results outstanding", 64'(expected_q.size()), 0);
    repeat (40) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_q24();
    case ($urandom_range(0, 5))
      0:       return 32'h0;
      1:       return 32'hFFFF_FFFF;
      default: return $urandom >> $urandom_range(0, 31);
    endcase
  endfunction

  function automatic logic signed [15:0] pick_sample(input logic signed [15:0] level);
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 5) return 16'($urandom);
    if (sel < 9) return level + 16'($urandom_range(0, 511)) - 16'sd256;
    return sel[0] ? 16'sh7FFF : 16'sh8000;
  endfunction

  // stimulus
  initial begin
    int               ph, k;
    logic signed [15:0] lvl;
    err_count         = 0;
    no_idle           = 1'b0;
    rst_n             = 1'b0;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    in_if.valid       = 1'b0;
    in_if.measurement = '0;
    out_if.ready      = 1'b0;
    pnoise_q          = 32'd17;
    mnoise_q          = 32'd1677722;
    init_est_q        = 16'sd6400;
    init_cov_q        = 32'd83886080;
    est_q             = init_est_q;
    cov_q             = init_cov_q;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    repeat (3) @(posedge clk);

    // reset configuration: full-scale steps, small steps and the reset estimate value
    sample_q = '{16'sh7FFF, 16'sh8000, 16'sh0000, 16'shFFFF,
                 16'sh0001, 16'sh7FFF, 16'sh8000, 16'sh1900};
    wait_idle();

    // no noise: unity gain on the first step, then a zero denominator
    set_filter(32'h0, 32'h0, 16'sh0000, 32'h0100_0000);
    sample_q = '{16'sh8000, 16'sh7FFF, 16'sh1234};
    wait_idle();

    // everything at full scale: covariance saturation
    set_filter(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'sh8000, 32'hFFFF_FFFF);
    sample_q = '{16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh0000};
    wait_idle();

    // zero covariance, minimal measurement noise: zero gain
    set_filter(32'h0, 32'h1, 16'sh7FFF, 32'h0);
    sample_q = '{16'sh8000, 16'sh8000};
    wait_idle();

    // large process noise with zero measurement noise
    set_filter(32'hFFFF_FFFF, 32'h0, 16'sh8000, 32'h0);
    sample_q = '{16'sh7FFF, 16'sh8000};
    wait_idle();

    // random configurations, each followed by a run of samples
    for (ph = 0; ph < 13; ph++) begin
      lvl = ($urandom_range(0, 3) == 0) ? ($urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000)
                                         : 16'($urandom);
      set_filter(pick_q24(), pick_q24(), lvl, pick_q24());
      no_idle = ($urandom_range(0, 3) == 0);
      for (k = 0; k < 100; k++) sample_q.push_back(pick_sample(lvl));
      wait_idle();
    end

    no_idle = 1'b0;
    wait_idle();
    if (err_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== scalar_kalman_filter.f =====
+incdir+src
src/skf_pkg.sv
src/skf_in_if.sv
src/skf_out_if.sv
src/skf_regs.sv
src/skf_seq.sv
src/skf_dp.sv
src/scalar_kalman_filter.sv
tb/sv/tb_top.sv
